@@ rtl/cft_pkg.sv @@
// ----------------------------------------------------------------------------
// cft_pkg
// Shared types and constants for the CSV field tokenizer.
// ----------------------------------------------------------------------------
package cft_pkg;

   // result kinds
   localparam logic [1:0] KIND_DATA  = 2'd0;
   localparam logic [1:0] KIND_FIELD = 2'd1;
   localparam logic [1:0] KIND_ROW   = 2'd2;

   // field modes
   localparam logic [1:0] MODE_START  = 2'd0;
   localparam logic [1:0] MODE_PLAIN  = 2'd1;
   localparam logic [1:0] MODE_QUOTED = 2'd2;
   localparam logic [1:0] MODE_SKIP   = 2'd3;

   // register indexes
   localparam logic [1:0] REG_DELIMITER = 2'd0;
   localparam logic [1:0] REG_QUOTE     = 2'd1;
   localparam logic [1:0] REG_ESCAPE    = 2'd2;

   localparam logic [7:0] RST_DELIMITER = 8'd44;
   localparam logic [7:0] RST_QUOTE     = 8'd34;
   localparam logic [7:0] RST_ESCAPE    = 8'd92;

   localparam logic [7:0] ASCII_LF = 8'd10;
   localparam logic [7:0] ASCII_CR = 8'd13;

   // results per feed step and per input item
   localparam int FeedMaxRes = 3;
   localparam int GroupDepth = 4;
   localparam int GroupCntW  = $clog2(GroupDepth + 1);
   localparam int GroupIdxW  = $clog2(GroupDepth);

   typedef enum logic [1:0] {
      OP_NONE = 2'd0,
      OP_BYTE = 2'd1,
      OP_END  = 2'd2
   } cft_op_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
   } cft_result_type;

   typedef struct packed {
      logic [7:0] held_byte;
      logic       held_valid;
      logic [1:0] field_mode;
      logic       after_escape;
      logic       field_consumed;
   } cft_field_state_type;

   typedef struct packed {
      logic [7:0] delimiter;
      logic [7:0] quote;
      logic [7:0] escape;
   } cft_cfg_type;

endpackage

@@ rtl/cft_feed.sv @@
// ----------------------------------------------------------------------------
// cft_feed
// One field-level step: feeds one byte or closes the row, with one byte of
// lookahead for escapes and doubled quotes. Purely combinational.
// ----------------------------------------------------------------------------
module cft_feed
   import cft_pkg::*;
(
   input  cft_cfg_type                          cfg,
   input  cft_op_type                           op,
   input  logic [7:0]                           op_byte,
   input  cft_field_state_type                  st_cur,
   output cft_field_state_type                  st_next,
   output cft_result_type [FeedMaxRes-1:0]      res,
   output logic [1:0]                           res_cnt
);

   always_comb begin : feed_logic
      cft_field_state_type              s;
      cft_result_type [FeedMaxRes-1:0]  r;
      logic [7:0]                       p0;
      logic                             dq;
      logic                             hold_esc;
      logic                             do_resolve;
      logic                             in_quote;
      logic [1:0]                       n;

      s          = st_cur;
      r          = '0;
      p0         = st_cur.held_byte;
      dq         = 1'b0;
      hold_esc   = 1'b0;
      do_resolve = 1'b0;
      in_quote   = 1'b0;
      n          = 2'd0;

      // resolve the held byte now that the next one is known
      if (op != OP_NONE && s.held_valid) begin
         if (op == OP_BYTE && !s.after_escape && p0 == cfg.escape) begin
            hold_esc       = 1'b1;
            s.held_byte    = op_byte;
            s.after_escape = 1'b1;
         end else begin
            dq             = (op == OP_BYTE) && (p0 == cfg.quote) && (op_byte == cfg.quote);
            s.held_valid   = 1'b0;
            s.held_byte    = 8'h00;
            s.after_escape = 1'b0;
            do_resolve     = 1'b1;
         end
      end

      if (do_resolve) begin
         in_quote = (s.field_mode == MODE_QUOTED) && !dq;
         if ((in_quote && p0 == cfg.quote) || (!in_quote && p0 == cfg.delimiter)) begin
            r[0]             = '{kind: KIND_FIELD, data: 8'h00};
            s.field_mode     = (s.field_mode == MODE_QUOTED) ? MODE_SKIP : MODE_START;
            s.field_consumed = 1'b0;
         end else begin
            r[0] = '{kind: KIND_DATA, data: p0};
         end
         n = 2'd1;
      end

      // take the new byte, unless it was swallowed by an escape or a doubled quote
      if (op == OP_BYTE && !hold_esc && !dq) begin
         case (s.field_mode)
            MODE_START: begin
               s.field_consumed = 1'b1;
               if (op_byte == cfg.quote) begin
                  s.field_mode = MODE_QUOTED;
               end else begin
                  s.field_mode   = MODE_PLAIN;
                  s.held_byte    = op_byte;
                  s.held_valid   = 1'b1;
                  s.after_escape = 1'b0;
               end
            end
            MODE_PLAIN, MODE_QUOTED: begin
               s.held_byte  = op_byte;
               s.held_valid = 1'b1;
            end
            default: begin
               if (op_byte == cfg.delimiter) begin
                  s.field_mode = MODE_START;
               end
            end
         endcase
      end

      // close the row
      if (op == OP_END) begin
         if (s.field_consumed) begin
            r[n] = '{kind: KIND_FIELD, data: 8'h00};
            n    = n + 2'd1;
         end
         r[n] = '{kind: KIND_ROW, data: 8'h00};
         n    = n + 2'd1;
         s    = '0;
      end

      st_next = s;
      res     = r;
      res_cnt = n;
   end

endmodule

@@ rtl/cft_rsp_buf.sv @@
// ----------------------------------------------------------------------------
// cft_rsp_buf
// Holds the result group of one item and hands it out one item per beat.
// ----------------------------------------------------------------------------
module cft_rsp_buf
   import cft_pkg::*;
(
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                load,
   input  cft_result_type [GroupDepth-1:0]     load_grp,
   input  logic [GroupCntW-1:0]                load_cnt,
   output logic                                free,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [7:0]                          rsp_tdata,  // out_byte[7:0]
   output logic [1:0]                          rsp_tuser,  // kind[1:0]
   output logic                                rsp_tlast
);

   cft_result_type [GroupDepth-1:0] grp_ff;
   logic [GroupCntW-1:0]            cnt_ff, cnt_in;
   logic [GroupIdxW-1:0]            idx_ff, idx_in;
   logic                            at_last;
   logic                            pop;

   assign at_last    = ({1'b0, idx_ff} + 1'b1) == cnt_ff;
   assign rsp_tvalid = (cnt_ff != '0);
   assign pop        = rsp_tvalid && rsp_tready;
   assign free       = !rsp_tvalid || (pop && at_last);

   assign rsp_tdata = grp_ff[idx_ff].data;
   assign rsp_tuser = grp_ff[idx_ff].kind;
   assign rsp_tlast = at_last;

   always_comb begin
      cnt_in = cnt_ff;
      idx_in = idx_ff;
      if (pop) begin
         if (at_last) begin
            cnt_in = '0;
            idx_in = '0;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end
      if (load) begin
         cnt_in = load_cnt;
         idx_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         idx_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         grp_ff <= load_grp;
      end
   end

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ({1'b0, idx_ff} < cnt_ff))
      else $error("result index beyond group count");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      load |-> free)
      else $error("group loaded over undelivered results");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      (pop && at_last && !load) |=> !rsp_tvalid)
      else $error("results still pending after last of group");

endmodule

@@ rtl/csv_field_tokenizer_core.sv @@
// ----------------------------------------------------------------------------
// csv_field_tokenizer_core
// Streaming CSV tokenizer: file bytes in, field bytes with field-end and
// row-end marks out.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake                payload
//  -------  ---  -----------------------  -------------------------------------
//  req      in   req_tvalid/req_tready    tdata = in_byte, tuser = func
//  rsp      out  rsp_tvalid/rsp_tready    tdata = out_byte, tuser = kind,
//                                         tlast = last
//  csr      in   csr_valid/csr_ready      csr_index, csr_data (always ready)
//
//  Flow: an item is decoded in the cycle it is accepted and its results
//  (0 to 4) are registered as one group. The single result port drains
//  the group register, and req_tready stays low while a group holds
//  results, until its last result leaves.
//  Reset: synchronous, active high; clears the row state and loads the
//  default delimiter, quote and escape bytes.
//  Stalls: req_tready follows rsp_tready while the last result of a group
//  waits, so a new item is taken in the cycle that result leaves.
//
module csv_field_tokenizer_core
   import cft_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   // input items
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // in_byte[7:0]
   input  logic       req_tuser,   // func[0]
   // result items
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // out_byte[7:0]
   output logic [1:0] rsp_tuser,   // kind[1:0]
   output logic       rsp_tlast,
   // register writes
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_data
);

   // register file
   cft_cfg_type cfg_ff;

   // row-level state; field-level state lives in st_ff
   cft_field_state_type st_ff;
   logic                parity_ff, parity_in;
   logic                row_open_ff, row_open_in;
   logic                cr_pending_ff, cr_pending_in;

   logic accept;
   logic buf_free;
   logic ends_row;

   // two chained feed steps: an optional held CR, then the byte or end of row
   cft_op_type                      op_a, op_b;
   logic [7:0]                      byte_b;
   cft_field_state_type             st_a, st_b;
   cft_result_type [FeedMaxRes-1:0] res_a, res_b;
   logic [1:0]                      cnt_a, cnt_b;

   cft_result_type [GroupDepth-1:0] grp;
   logic [GroupCntW-1:0]            grp_cnt;

   assign csr_ready  = 1'b1;
   assign req_tready = buf_free;
   assign accept     = req_tvalid && req_tready;
   assign byte_b     = req_tdata;

   // row scan: quote parity, LF row end, CR held one byte
   always_comb begin
      op_a          = OP_NONE;
      op_b          = OP_NONE;
      parity_in     = parity_ff;
      row_open_in   = row_open_ff;
      cr_pending_in = cr_pending_ff;
      ends_row      = 1'b0;

      if (req_tuser) begin
         // end of input closes an open row, keeping a held CR as data
         if (row_open_ff) begin
            op_a = cr_pending_ff ? OP_BYTE : OP_NONE;
            op_b = OP_END;
         end
      end else if (req_tdata != 8'h00) begin
         row_open_in = 1'b1;
         if (req_tdata == cfg_ff.quote) begin
            parity_in = ~parity_ff;
         end
         ends_row = (req_tdata != cfg_ff.quote) && (req_tdata == ASCII_LF) && !parity_ff;
         if (ends_row) begin
            // CR before the row-ending LF is dropped
            op_b = OP_END;
         end else begin
            op_a          = cr_pending_ff ? OP_BYTE : OP_NONE;
            cr_pending_in = (req_tdata == ASCII_CR);
            op_b          = (req_tdata == ASCII_CR) ? OP_NONE : OP_BYTE;
         end
      end

      if (op_b == OP_END) begin
         parity_in     = 1'b0;
         row_open_in   = 1'b0;
         cr_pending_in = 1'b0;
      end
   end

   cft_feed u_feed_a (
      .cfg     (cfg_ff),
      .op      (op_a),
      .op_byte (ASCII_CR),
      .st_cur  (st_ff),
      .st_next (st_a),
      .res     (res_a),
      .res_cnt (cnt_a)
   );

   cft_feed u_feed_b (
      .cfg     (cfg_ff),
      .op      (op_b),
      .op_byte (byte_b),
      .st_cur  (st_a),
      .st_next (st_b),
      .res     (res_b),
      .res_cnt (cnt_b)
   );

   // step A gives at most one result; step B's follow it
   always_comb begin
      grp = '0;
      if (cnt_a != 2'd0) begin
         grp[0] = res_a[0];
         grp[1] = res_b[0];
         grp[2] = res_b[1];
         grp[3] = res_b[2];
      end else begin
         grp[0] = res_b[0];
         grp[1] = res_b[1];
         grp[2] = res_b[2];
      end
      grp_cnt = GroupCntW'(cnt_a) + GroupCntW'(cnt_b);
   end

   cft_rsp_buf u_rsp_buf (
      .clock      (clock),
      .reset      (reset),
      .load       (accept),
      .load_grp   (grp),
      .load_cnt   (grp_cnt),
      .free       (buf_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff         <= '0;
         parity_ff     <= 1'b0;
         row_open_ff   <= 1'b0;
         cr_pending_ff <= 1'b0;
      end else if (accept) begin
         st_ff         <= st_b;
         parity_ff     <= parity_in;
         row_open_ff   <= row_open_in;
         cr_pending_ff <= cr_pending_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.delimiter <= RST_DELIMITER;
         cfg_ff.quote     <= RST_QUOTE;
         cfg_ff.escape    <= RST_ESCAPE;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_DELIMITER: cfg_ff.delimiter <= csr_data;
            REG_QUOTE:     cfg_ff.quote     <= csr_data;
            REG_ESCAPE:    cfg_ff.escape    <= csr_data;
            default: begin
            end
         endcase
      end
   end

   a_cr_in_row: assert property (@(posedge clock) disable iff (reset)
      cr_pending_ff |-> row_open_ff)
      else $error("CR held outside an open row");

   a_held_in_row: assert property (@(posedge clock) disable iff (reset)
      st_ff.held_valid |-> row_open_ff)
      else $error("byte held outside an open row");

   a_group_fits: assert property (@(posedge clock) disable iff (reset)
      accept |-> (grp_cnt <= GroupCntW'(GroupDepth)))
      else $error("result group larger than the group register");

endmodule
